// ----- hw/rtl/rbnh_pkg.sv -----
// ray box nearest hit: shared types, constants and register indexes
// no dependencies

package rbnh_pkg;

  localparam int unsigned MaxBoxesDefault = 1024;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [30:0] MaxDistReset = 31'd262144;
  localparam logic [17:0] DirZReset = 18'sd65536;

  // numerator (bound - origin) << 16 fits in 50 bits signed
  localparam int unsigned NumW = 50;
  localparam int unsigned DenW = 18;
  localparam int unsigned QuoW = 50;
  localparam int unsigned CntW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_MAX_DIST = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [29:0] half_x;
    logic [29:0] half_y;
    logic [29:0] half_z;
    logic eligible;
    logic last_box;
  } box_req_t;

  typedef struct packed {
    logic hit;
    logic [9:0] hit_index;
    logic [30:0] hit_distance;
  } hit_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_AXIS_DONE,
    ST_COMMIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- hw/rtl/rbnh_divider.sv -----
// ray box nearest hit: bit-serial signed divider, one quotient bit per cycle
// uses rbnh_pkg

module rbnh_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [rbnh_pkg::NumW-1:0] num,
  input  logic signed [rbnh_pkg::DenW-1:0] den,
  output rbnh_pkg::div_ctl_t ctl,
  output logic signed [rbnh_pkg::QuoW-1:0] quo
);
  import rbnh_pkg::*;

  logic [NumW-1:0] rem_q;      // shifting dividend / quotient
  logic [DenW:0] part;         // partial remainder
  logic [DenW-1:0] dmag;
  logic neg;
  logic [CntW-1:0] cnt;
  logic busy;
  logic done;

  logic [DenW:0] trial;
  logic [DenW:0] shifted;

  always_comb begin
    shifted = {part[DenW-1:0], rem_q[NumW-1]};
    trial = shifted - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= num[NumW-1] ? NumW'(-num) : num;
      dmag <= den[DenW-1] ? DenW'(-den) : den;
      neg <= num[NumW-1] ^ den[DenW-1];
      part <= '0;
    end else if (busy) begin
      if (!trial[DenW]) begin
        part <= trial;
        rem_q <= {rem_q[NumW-2:0], 1'b1};
      end else begin
        part <= shifted;
        rem_q <= {rem_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -$signed(rem_q) : $signed(rem_q);
  assign ctl = '{start: start, busy: busy, done: done};

endmodule

// ----- hw/rtl/ray_box_nearest_hit_unit.sv -----
// ray box nearest hit: top level with config registers, slab sequencer, best tracking
// uses rbnh_pkg and rbnh_divider
// sequence: each box runs SETUP, then per axis two serial divisions of 50 bits and an
// AXIS_DONE step, then COMMIT; an ineligible box goes from SETUP straight to COMMIT
// throughput: one box at a time, less time for a parallel axis (no division) or an
// early miss; rst is synchronous, restores config and search

module ray_box_nearest_hit_unit #(
  parameter int unsigned MAX_BOXES = rbnh_pkg::MaxBoxesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rbnh_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rbnh_pkg::CfgDataW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  rbnh_pkg::box_req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rbnh_pkg::hit_rsp_t out_data
);
  import rbnh_pkg::*;

  localparam int unsigned BcW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // config registers
  logic signed [31:0] origin [3];
  logic signed [17:0] dir [3];
  logic [30:0] max_distance;

  // search state
  logic signed [49:0] best_distance;
  logic [9:0] best_index;
  logic found;
  logic [BcW-1:0] box_count;

  ctrl_state_t state, state_next;
  box_req_t box;
  logic [1:0] axis;
  logic second;            // second bound of the axis in flight
  logic miss;
  logic signed [49:0] entry, exit_t, t_first;

  // divider hookup
  logic div_start;
  logic signed [NumW-1:0] div_num;
  div_ctl_t div_ctl;
  logic signed [QuoW-1:0] div_quo;

  rbnh_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(div_num), .den(dir[axis]), .ctl(div_ctl), .quo(div_quo)
  );

  // per-axis bound selection
  logic signed [33:0] c_ax, h_ax, o_ax, lo, hi;
  always_comb begin
    case (axis)
      2'd0: begin c_ax = 34'(box.center_x); h_ax = {4'd0, box.half_x}; end
      2'd1: begin c_ax = 34'(box.center_y); h_ax = {4'd0, box.half_y}; end
      default: begin c_ax = 34'(box.center_z); h_ax = {4'd0, box.half_z}; end
    endcase
    o_ax = 34'(origin[axis]);
    lo = c_ax - h_ax;
    hi = c_ax + h_ax;
    div_num = second ? {50'(hi - o_ax)} <<< 16 : {50'(lo - o_ax)} <<< 16;
  end

  logic parallel;
  assign parallel = (dir[axis] == '0);

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = box.eligible ? ST_DIV_START : ST_COMMIT;
      ST_DIV_START: state_next = parallel ? ST_AXIS_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_ctl.done) state_next = second ? ST_AXIS_DONE : ST_DIV_START;
      ST_AXIS_DONE: state_next = (miss || axis == 2'd2) ? ST_COMMIT : ST_DIV_START;
      ST_COMMIT: state_next = box.last_box ? ST_OUT : ST_IDLE;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    div_start = (state == ST_DIV_START) && !parallel;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // t ordering for the two bounds
  logic signed [49:0] t_near, t_far, entry_n, exit_n;
  always_comb begin
    t_near = (t_first > div_quo) ? div_quo : t_first;
    t_far = (t_first > div_quo) ? t_first : div_quo;
    entry_n = (t_near > entry) ? t_near : entry;
    exit_n = (t_far < exit_t) ? t_far : exit_t;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) box <= in_data;
    case (state)
      ST_SETUP: begin
        axis <= 2'd0;
        second <= 1'b0;
        miss <= 1'b0;
        entry <= '0;
        exit_t <= best_distance;
      end
      ST_DIV_START: if (parallel) begin
        miss <= (o_ax < lo) || (o_ax > hi);
      end
      ST_DIV_WAIT: if (div_ctl.done) begin
        if (!second) begin
          t_first <= div_quo;
          second <= 1'b1;
        end else begin
          entry <= entry_n;
          exit_t <= exit_n;
          miss <= entry_n > exit_n;
        end
      end
      ST_AXIS_DONE: begin
        axis <= axis + 2'd1;
        second <= 1'b0;
      end
      default: ;
    endcase
  end

  // config and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0; origin[1] <= '0; origin[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= DirZReset;
      max_distance <= MaxDistReset;
      best_distance <= 50'(MaxDistReset);
      best_index <= '0;
      found <= 1'b0;
      box_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: origin[0] <= cfg_data;
          REG_ORIGIN_Y: origin[1] <= cfg_data;
          REG_ORIGIN_Z: origin[2] <= cfg_data;
          REG_DIR_X: dir[0] <= cfg_data[17:0];
          REG_DIR_Y: dir[1] <= cfg_data[17:0];
          REG_DIR_Z: dir[2] <= cfg_data[17:0];
          REG_MAX_DIST: begin
            max_distance <= cfg_data[30:0];
            if (!found) best_distance <= 50'(cfg_data[30:0]);
          end
          default: ;
        endcase
      end
      if (state == ST_COMMIT) begin
        if (box.eligible && !miss) begin
          best_distance <= entry;
          best_index <= 10'(box_count);
          found <= 1'b1;
        end
        box_count <= (32'(box_count) == MAX_BOXES - 1) ? '0 : box_count + 1'b1;
      end
      if (state == ST_COMMIT && box.last_box) begin
        out_data.hit <= found || (box.eligible && !miss);
        out_data.hit_index <= (box.eligible && !miss) ? 10'(box_count)
                              : (found ? best_index : '0);
        out_data.hit_distance <= (box.eligible && !miss) ? entry[30:0]
                                 : (found ? best_distance[30:0] : '0);
      end
      if (state == ST_OUT && out_ready) begin
        best_distance <= 50'(max_distance);
        best_index <= '0;
        found <= 1'b0;
        box_count <= '0;
      end
    end
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_ctl.busy)
    else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
`endif

endmodule
